// ----- rtl/core/wfte_pkg.sv -----
// ----------------------------------------------------------------------------
// wfte_pkg
// shared types and codes of the wildcard flow table engine
// ----------------------------------------------------------------------------
package wfte_pkg;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2,
      OP_DRAIN  = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_FORWARD   = 4'd0,
      ST_CONTROL   = 4'd1,
      ST_DROP      = 4'd2,
      ST_MISS_LOG  = 4'd3,
      ST_BYPASS    = 4'd4,
      ST_LOG_FULL  = 4'd5,
      ST_INSERTED  = 4'd6,
      ST_UPDATED   = 4'd7,
      ST_TBL_FULL  = 4'd8,
      ST_DELETED   = 4'd9,
      ST_NOT_FOUND = 4'd10,
      ST_RECORD    = 4'd11,
      ST_LOG_EMPTY = 4'd12
   } status_type;

   localparam logic [7:0] ACT_FORWARD = 8'd0;
   localparam logic [7:0] ACT_CONTROL = 8'd2;

   // one table entry
   typedef struct packed {
      logic [63:0] src_hi;
      logic [63:0] src_lo;
      logic [63:0] dst_hi;
      logic [63:0] dst_lo;
      logic [63:0] hop_hi;
      logic [63:0] hop_lo;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [7:0]  proto;
      logic [7:0]  action;
      logic [7:0]  fid;
   } entry_type;

   // per-cell command from the top level
   typedef struct packed {
      logic      write_sel;   // load this cell from the new entry
      logic      shift_up;    // load this cell from its lower neighbor
   } cell_ctl_type;

   // per-cell compare flags
   typedef struct packed {
      logic      pkt_hit;
      logic      fid_hit;
   } cell_flag_type;

endpackage

// ----- rtl/core/wildcard_flow_table_engine.sv -----
// ----------------------------------------------------------------------------
// wildcard_flow_table_engine
// ordered wildcard flow table in a chain of cells, with a packet-in miss log
// ----------------------------------------------------------------------------
//  channel | ports          | transfer
//  --------+----------------+-------------------------------------------
//  request | req_*, start   | start high while busy low
//  result  | rsp_*, rsp_vld | one cycle strobe, cannot be held off
//  config  | csr_*          | csr_wr_en high, write takes effect at once
//
// on accept the request is registered; the cells compare in parallel in the next
// cycle, and the table / log update and the result register load at its end.
// busy is high for that one cycle, so a new item can start while rsp_vld is high.
// the log read goes through the registered ram port, addressed from the count
// ahead of time. reset is synchronous; it clears the counts, busy and rsp_vld
// and loads the reserved port with 5683. cell contents stay undefined until
// written.
module wildcard_flow_table_engine #(
   parameter int TABLE_DEPTH = 32,
   parameter int LOG_DEPTH   = 20
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_flow_id,
   input  logic [63:0] req_src_addr_hi,
   input  logic [63:0] req_src_addr_lo,
   input  logic [63:0] req_dst_addr_hi,
   input  logic [63:0] req_dst_addr_lo,
   input  logic [15:0] req_src_port,
   input  logic [15:0] req_dst_port,
   input  logic [7:0]  req_protocol,
   input  logic [7:0]  req_action_code,
   input  logic [63:0] req_hop_addr_hi,
   input  logic [63:0] req_hop_addr_lo,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   output logic        rsp_vld,
   output logic [3:0]  rsp_status,
   output logic [63:0] rsp_next_hop_hi,
   output logic [63:0] rsp_next_hop_lo,
   output logic [4:0]  rsp_entry_index,
   output logic [5:0]  rsp_entry_total,
   output logic [7:0]  rsp_log_src_byte,
   output logic [7:0]  rsp_log_dst_byte,
   output logic [15:0] rsp_log_src_port,
   output logic [15:0] rsp_log_dst_port,
   output logic [4:0]  rsp_log_total
);

   localparam int TIW = $clog2(TABLE_DEPTH);
   localparam int TCW = $clog2(TABLE_DEPTH + 1);
   localparam int LIW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
   localparam int LCW = $clog2(LOG_DEPTH + 1);
   localparam int RDP = (LOG_DEPTH > 1) ? LOG_DEPTH : 2;

   // config register
   logic [15:0] rsv_port_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsv_port_ff <= 16'd5683;
      end else if (csr_wr_en) begin
         rsv_port_ff <= csr_wr_data;
      end
   end

   // request register
   logic                busy_ff;
   wfte_pkg::op_type    op_ff;
   wfte_pkg::entry_type req_ff;
   wfte_pkg::entry_type req_in;

   always_comb begin
      req_in.src_hi = req_src_addr_hi;
      req_in.src_lo = req_src_addr_lo;
      req_in.dst_hi = req_dst_addr_hi;
      req_in.dst_lo = req_dst_addr_lo;
      req_in.hop_hi = req_hop_addr_hi;
      req_in.hop_lo = req_hop_addr_lo;
      req_in.sport  = req_src_port;
      req_in.dport  = req_dst_port;
      req_in.proto  = req_protocol;
      req_in.action = req_action_code;
      req_in.fid    = req_flow_id;
   end

   wire accept = start && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= accept;
      end
      if (accept) begin
         op_ff  <= wfte_pkg::op_type'(req_opcode);
         req_ff <= req_in;
      end
   end
   assign busy = busy_ff;

   logic [TCW-1:0] ent_cnt_ff;
   logic [LCW-1:0] log_cnt_ff;

   // cell chain
   wfte_pkg::entry_type     cell_entry [TABLE_DEPTH];
   wfte_pkg::cell_flag_type cell_flag  [TABLE_DEPTH];
   wfte_pkg::cell_ctl_type  cell_ctl   [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]  pkt_vec;
   logic [TABLE_DEPTH-1:0]  fid_vec;

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      // last cell takes itself from below, never shifted into anyway
      wfte_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl[g]),
         .new_entry  (req_ff),
         .from_below (cell_entry[(g + 1 < TABLE_DEPTH) ? g + 1 : g]),
         .key_src_hi (req_ff.src_hi),
         .key_src_lo (req_ff.src_lo),
         .key_dst_hi (req_ff.dst_hi),
         .key_dst_lo (req_ff.dst_lo),
         .key_sport  (req_ff.sport),
         .key_dport  (req_ff.dport),
         .key_proto  (req_ff.proto),
         .key_fid    (req_ff.fid),
         .entry      (cell_entry[g]),
         .flag       (cell_flag[g])
      );
      // only cells below the count take part
      assign pkt_vec[g] = cell_flag[g].pkt_hit && (TCW'(g) < ent_cnt_ff);
      assign fid_vec[g] = cell_flag[g].fid_hit && (TCW'(g) < ent_cnt_ff);
   end

   // first-hit priority pick
   logic           pkt_any, fid_any;
   logic [TIW-1:0] pkt_pos, fid_pos;
   always_comb begin
      pkt_any = 1'b0;
      fid_any = 1'b0;
      pkt_pos = '0;
      fid_pos = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (pkt_vec[i]) begin
            pkt_any = 1'b1;
            pkt_pos = TIW'(i);
         end
         if (fid_vec[i]) begin
            fid_any = 1'b1;
            fid_pos = TIW'(i);
         end
      end
   end

   wfte_pkg::entry_type pkt_ent;
   assign pkt_ent = cell_entry[pkt_pos];

   wire bypass  = (req_ff.sport == rsv_port_ff) || (req_ff.dport == rsv_port_ff);
   wire do_look = busy_ff && (op_ff == wfte_pkg::OP_LOOKUP);
   wire do_ins  = busy_ff && (op_ff == wfte_pkg::OP_INSERT);
   wire do_del  = busy_ff && (op_ff == wfte_pkg::OP_DELETE);
   wire do_drn  = busy_ff && (op_ff == wfte_pkg::OP_DRAIN);
   wire tbl_room = ent_cnt_ff < TCW'(TABLE_DEPTH);
   wire log_room = log_cnt_ff < LCW'(LOG_DEPTH);
   wire log_push = do_look && !bypass && !pkt_any && log_room;
   wire log_pop  = do_drn && (log_cnt_ff != '0);
   wire ins_new  = do_ins && !fid_any && tbl_room;

   logic [TIW-1:0] ins_pos;
   assign ins_pos = fid_any ? fid_pos : ent_cnt_ff[TIW-1:0];

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_ctl
      assign cell_ctl[g].write_sel = do_ins && (fid_any || tbl_room)
         && (ins_pos == TIW'(g));
      assign cell_ctl[g].shift_up = do_del && fid_any && (TIW'(g) >= fid_pos);
   end

   // counters
   always_ff @(posedge clock) begin
      if (reset) begin
         ent_cnt_ff <= '0;
         log_cnt_ff <= '0;
      end else begin
         if (ins_new) begin
            ent_cnt_ff <= ent_cnt_ff + TCW'(1);
         end else if (do_del && fid_any) begin
            ent_cnt_ff <= ent_cnt_ff - TCW'(1);
         end
         if (log_push) begin
            log_cnt_ff <= log_cnt_ff + LCW'(1);
         end else if (log_pop) begin
            log_cnt_ff <= log_cnt_ff - LCW'(1);
         end
      end
   end

   // miss log ram: read top record at accept, valid during the work cycle
   logic [47:0]    log_rd;
   logic [LCW-1:0] top_idx;
   assign top_idx = log_cnt_ff - LCW'(1);
   wfte_ram #(
      .WIDTH (48),
      .DEPTH (RDP)
   ) u_log (
      .clock   (clock),
      .wr_en   (log_push),
      .wr_addr (log_cnt_ff[LIW-1:0]),
      .wr_data ({req_ff.dst_lo[7:0], req_ff.src_lo[7:0], req_ff.dport, req_ff.sport}),
      .rd_addr (top_idx[LIW-1:0]),
      .rd_data (log_rd)
   );

   // result register
   logic        vld_ff;
   logic [3:0]  st_ff;
   logic [63:0] hh_ff, hl_ff;
   logic [4:0]  idx_ff;
   logic [47:0] rec_ff;
   logic [3:0]  st_in;
   logic [63:0] hh_in, hl_in;
   logic [4:0]  idx_in;

   always_comb begin
      st_in  = wfte_pkg::ST_LOG_EMPTY;
      hh_in  = '0;
      hl_in  = '0;
      idx_in = '0;
      unique case (op_ff)
         wfte_pkg::OP_LOOKUP: begin
            if (bypass) begin
               st_in = wfte_pkg::ST_BYPASS;
            end else if (pkt_any) begin
               idx_in = 5'(pkt_pos);
               if (pkt_ent.action == wfte_pkg::ACT_FORWARD) begin
                  st_in = wfte_pkg::ST_FORWARD;
                  hh_in = pkt_ent.hop_hi;
                  hl_in = pkt_ent.hop_lo;
               end else if (pkt_ent.action == wfte_pkg::ACT_CONTROL) begin
                  st_in = wfte_pkg::ST_CONTROL;
               end else begin
                  st_in = wfte_pkg::ST_DROP;
               end
            end else if (log_room) begin
               st_in = wfte_pkg::ST_MISS_LOG;
            end else begin
               st_in = wfte_pkg::ST_LOG_FULL;
            end
         end
         wfte_pkg::OP_INSERT: begin
            if (fid_any) begin
               st_in  = wfte_pkg::ST_UPDATED;
               idx_in = 5'(ins_pos);
            end else if (tbl_room) begin
               st_in  = wfte_pkg::ST_INSERTED;
               idx_in = 5'(ins_pos);
            end else begin
               st_in = wfte_pkg::ST_TBL_FULL;
            end
         end
         wfte_pkg::OP_DELETE: begin
            if (fid_any) begin
               st_in  = wfte_pkg::ST_DELETED;
               idx_in = 5'(fid_pos);
            end else begin
               st_in = wfte_pkg::ST_NOT_FOUND;
            end
         end
         wfte_pkg::OP_DRAIN: begin
            st_in = log_pop ? wfte_pkg::ST_RECORD : wfte_pkg::ST_LOG_EMPTY;
         end
         default: st_in = wfte_pkg::ST_LOG_EMPTY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= busy_ff;
      end
      if (busy_ff) begin
         st_ff  <= st_in;
         hh_ff  <= hh_in;
         hl_ff  <= hl_in;
         idx_ff <= idx_in;
         rec_ff <= log_pop ? log_rd : '0;
      end
   end

   assign rsp_vld          = vld_ff;
   assign rsp_status       = st_ff;
   assign rsp_next_hop_hi  = hh_ff;
   assign rsp_next_hop_lo  = hl_ff;
   assign rsp_entry_index  = idx_ff;
   assign rsp_entry_total  = 6'(ent_cnt_ff);
   assign rsp_log_src_byte = rec_ff[39:32];
   assign rsp_log_dst_byte = rec_ff[47:40];
   assign rsp_log_src_port = rec_ff[15:0];
   assign rsp_log_dst_port = rec_ff[31:16];
   assign rsp_log_total    = 5'(log_cnt_ff);

   // counts never exceed their stores
   a_ent_bound: assert property (@(posedge clock) disable iff (reset)
      ent_cnt_ff <= TCW'(TABLE_DEPTH)) else $error("entry count overrun");
   a_log_bound: assert property (@(posedge clock) disable iff (reset)
      log_cnt_ff <= LCW'(LOG_DEPTH)) else $error("log count overrun");
   // every accepted item is followed by a result strobe
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_vld) else $error("missing result");
   a_no_stray: assert property (@(posedge clock) disable iff (reset)
      rsp_vld |-> !busy_ff) else $error("result overlaps work");

endmodule

// ----- rtl/core/wfte_cell.sv -----
// ----------------------------------------------------------------------------
// wfte_cell
// one flow table slot: holds an entry, compares it, hands it up on delete
// ----------------------------------------------------------------------------
module wfte_cell (
   input  logic                    clock,
   input  wfte_pkg::cell_ctl_type  ctl,
   input  wfte_pkg::entry_type     new_entry,
   input  wfte_pkg::entry_type     from_below,
   input  logic [63:0]             key_src_hi,
   input  logic [63:0]             key_src_lo,
   input  logic [63:0]             key_dst_hi,
   input  logic [63:0]             key_dst_lo,
   input  logic [15:0]             key_sport,
   input  logic [15:0]             key_dport,
   input  logic [7:0]              key_proto,
   input  logic [7:0]              key_fid,
   output wfte_pkg::entry_type     entry,
   output wfte_pkg::cell_flag_type flag
);

   wfte_pkg::entry_type entry_ff;
   wfte_pkg::entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.write_sel) begin
         entry_in = new_entry;
      end else if (ctl.shift_up) begin
         entry_in = from_below;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

   always_comb begin
      flag.pkt_hit = (entry_ff.src_hi == key_src_hi) && (entry_ff.src_lo == key_src_lo)
         && (entry_ff.dst_hi == key_dst_hi) && (entry_ff.dst_lo == key_dst_lo)
         && ((entry_ff.sport == 16'd0) || (entry_ff.sport == key_sport))
         && ((entry_ff.dport == 16'd0) || (entry_ff.dport == key_dport))
         && ((entry_ff.proto == 8'd0) || (entry_ff.proto == key_proto));
      flag.fid_hit = (entry_ff.fid == key_fid);
   end

endmodule

// ----- rtl/core/wfte_ram.sv -----
// ----------------------------------------------------------------------------
// wfte_ram
// generic single-port write, single read ram with registered read
// ----------------------------------------------------------------------------
module wfte_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 20
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// flow table engine check: directed table rows, then random traffic, each
// result compared against an in-bench model of the table and the miss log
// ----------------------------------------------------------------------------
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_ENTRIES = 32;
   localparam int NUM_RECORDS = 20;
   localparam int RANDOM_ITEMS = 1100;
   localparam int STALL_LIMIT = 2000;
   localparam int NUM_ROWS = 22;

   // one request as driven on the req_ ports
   typedef struct {
      wfte_pkg::op_type op;
      logic [7:0]  fid;
      logic [63:0] src_hi, src_lo, dst_hi, dst_lo;
      logic [15:0] sport, dport;
      logic [7:0]  proto, action;
      logic [63:0] hop_hi, hop_lo;
   } request_type;

   // one result as seen on the rsp_ ports
   typedef struct {
      logic [3:0]  status;
      logic [63:0] hop_hi, hop_lo;
      logic [4:0]  index;
      logic [5:0]  total;
      logic [7:0]  src_byte, dst_byte;
      logic [15:0] src_port, dst_port;
      logic [4:0]  log_total;
   } result_type;

   // directed row: request, whether a typed answer is given, the status
   typedef struct {
      request_type          req;
      bit                   typed;
      wfte_pkg::status_type status;
   } row_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_opcode;
   logic [7:0]  req_flow_id;
   logic [63:0] req_src_addr_hi, req_src_addr_lo, req_dst_addr_hi, req_dst_addr_lo;
   logic [15:0] req_src_port, req_dst_port;
   logic [7:0]  req_protocol, req_action_code;
   logic [63:0] req_hop_addr_hi, req_hop_addr_lo;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;
   logic        rsp_vld;
   logic [3:0]  rsp_status;
   logic [63:0] rsp_next_hop_hi, rsp_next_hop_lo;
   logic [4:0]  rsp_entry_index;
   logic [5:0]  rsp_entry_total;
   logic [7:0]  rsp_log_src_byte, rsp_log_dst_byte;
   logic [15:0] rsp_log_src_port, rsp_log_dst_port;
   logic [4:0]  rsp_log_total;

   wildcard_flow_table_engine DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_flow_id(req_flow_id),
      .req_src_addr_hi(req_src_addr_hi), .req_src_addr_lo(req_src_addr_lo),
      .req_dst_addr_hi(req_dst_addr_hi), .req_dst_addr_lo(req_dst_addr_lo),
      .req_src_port(req_src_port), .req_dst_port(req_dst_port),
      .req_protocol(req_protocol), .req_action_code(req_action_code),
      .req_hop_addr_hi(req_hop_addr_hi), .req_hop_addr_lo(req_hop_addr_lo),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .rsp_vld(rsp_vld), .rsp_status(rsp_status),
      .rsp_next_hop_hi(rsp_next_hop_hi), .rsp_next_hop_lo(rsp_next_hop_lo),
      .rsp_entry_index(rsp_entry_index), .rsp_entry_total(rsp_entry_total),
      .rsp_log_src_byte(rsp_log_src_byte), .rsp_log_dst_byte(rsp_log_dst_byte),
      .rsp_log_src_port(rsp_log_src_port), .rsp_log_dst_port(rsp_log_dst_port),
      .rsp_log_total(rsp_log_total)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // model state of the table and the miss log
   wfte_pkg::entry_type flows [NUM_ENTRIES];
   int unsigned flow_count;
   logic [47:0] misses [NUM_RECORDS];
   int unsigned miss_count;
   logic [15:0] bypass_port;

   result_type  pending_results[$];
   int          error_count;
   int          row_errors;
   int          idle_cycles;

   // small pools so that lookups hit inserted entries and ids repeat
   logic [63:0] addr_pool [4];

   function automatic int find_fid(logic [7:0] fid);
      for (int i = 0; i < flow_count; i++)
         if (flows[i].fid == fid) return i;
      return -1;
   endfunction

   function automatic bit flow_hits(int i, request_type r);
      wfte_pkg::entry_type e;
      e = flows[i];
      if (e.src_hi != r.src_hi || e.src_lo != r.src_lo) return 0;
      if (e.dst_hi != r.dst_hi || e.dst_lo != r.dst_lo) return 0;
      if (e.sport != 0 && e.sport != r.sport) return 0;
      if (e.dport != 0 && e.dport != r.dport) return 0;
      if (e.proto != 0 && e.proto != r.proto) return 0;
      return 1;
   endfunction

   // advance the model by one request and return the result it causes
   function automatic result_type table_step(request_type r);
      result_type res;
      int         pos;
      logic [47:0] rec;
      res = '{default: '0};
      pos = -1;
      case (r.op)
         wfte_pkg::OP_LOOKUP: begin
            if (r.sport == bypass_port || r.dport == bypass_port) begin
               res.status = wfte_pkg::ST_BYPASS;
            end else begin
               for (int i = 0; i < flow_count; i++)
                  if (pos < 0 && flow_hits(i, r)) pos = i;
               if (pos >= 0) begin
                  res.index = 5'(pos);
                  if (flows[pos].action == wfte_pkg::ACT_FORWARD) begin
                     res.status = wfte_pkg::ST_FORWARD;
                     res.hop_hi = flows[pos].hop_hi;
                     res.hop_lo = flows[pos].hop_lo;
                  end else if (flows[pos].action == wfte_pkg::ACT_CONTROL) begin
                     res.status = wfte_pkg::ST_CONTROL;
                  end else begin
                     res.status = wfte_pkg::ST_DROP;
                  end
               end else if (miss_count < NUM_RECORDS) begin
                  misses[miss_count] = {r.dst_lo[7:0], r.src_lo[7:0], r.dport, r.sport};
                  miss_count++;
                  res.status = wfte_pkg::ST_MISS_LOG;
               end else begin
                  res.status = wfte_pkg::ST_LOG_FULL;
               end
            end
         end
         wfte_pkg::OP_INSERT: begin
            pos = find_fid(r.fid);
            if (pos >= 0) begin
               res.status = wfte_pkg::ST_UPDATED;
            end else if (flow_count < NUM_ENTRIES) begin
               pos = int'(flow_count);
               flow_count++;
               res.status = wfte_pkg::ST_INSERTED;
            end else begin
               res.status = wfte_pkg::ST_TBL_FULL;
            end
            if (pos >= 0) begin
               flows[pos] = '{r.src_hi, r.src_lo, r.dst_hi, r.dst_lo, r.hop_hi, r.hop_lo,
                              r.sport, r.dport, r.proto, r.action, r.fid};
               res.index = 5'(pos);
            end
         end
         wfte_pkg::OP_DELETE: begin
            pos = find_fid(r.fid);
            if (pos >= 0) begin
               for (int i = pos; i + 1 < flow_count; i++) flows[i] = flows[i + 1];
               flow_count--;
               res.index = 5'(pos);
               res.status = wfte_pkg::ST_DELETED;
            end else begin
               res.status = wfte_pkg::ST_NOT_FOUND;
            end
         end
         default: begin
            if (miss_count > 0) begin
               miss_count--;
               rec = misses[miss_count];
               res.src_byte = rec[39:32];
               res.dst_byte = rec[47:40];
               res.src_port = rec[15:0];
               res.dst_port = rec[31:16];
               res.status = wfte_pkg::ST_RECORD;
            end else begin
               res.status = wfte_pkg::ST_LOG_EMPTY;
            end
         end
      endcase
      res.total = 6'(flow_count);
      res.log_total = 5'(miss_count);
      return res;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // random request: mostly drawn from small pools so entries get hit
   function automatic request_type random_request();
      request_type r;
      int          mode;
      r.op     = wfte_pkg::op_type'($urandom_range(0, 3));
      mode     = $urandom_range(0, 9);
      r.fid    = (mode < 8) ? 8'($urandom_range(0, 39)) : 8'($urandom);
      r.src_hi = (mode < 8) ? addr_pool[$urandom_range(0, 3)] : rand64();
      r.src_lo = (mode < 8) ? addr_pool[$urandom_range(0, 3)] : rand64();
      r.dst_hi = (mode < 8) ? addr_pool[$urandom_range(0, 3)] : rand64();
      r.dst_lo = (mode < 8) ? addr_pool[$urandom_range(0, 3)] : rand64();
      r.sport  = (mode < 5) ? 16'($urandom_range(0, 3)) : 16'($urandom);
      r.dport  = (mode < 5) ? 16'($urandom_range(0, 3)) : 16'($urandom);
      r.proto  = (mode < 5) ? 8'($urandom_range(0, 2)) : 8'($urandom);
      r.action = (mode < 7) ? 8'($urandom_range(0, 3)) : 8'($urandom);
      r.hop_hi = rand64();
      r.hop_lo = rand64();
      // lookups dominate, with a bias toward the bypass port now and then
      if ($urandom_range(0, 9) < 3) r.op = wfte_pkg::OP_LOOKUP;
      if ($urandom_range(0, 30) == 0) r.sport = bypass_port;
      return r;
   endfunction

   // hold off, then present one request and wait for its transfer;
   // start is left high so a request with no gap follows at once
   task automatic send_request(request_type r, result_type exp);
      int idle;
      idle = $urandom_range(0, 6);
      if (idle > 0) begin
         start <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      pending_results.push_back(exp);
      start           <= 1'b1;
      req_opcode      <= r.op;
      req_flow_id     <= r.fid;
      req_src_addr_hi <= r.src_hi;
      req_src_addr_lo <= r.src_lo;
      req_dst_addr_hi <= r.dst_hi;
      req_dst_addr_lo <= r.dst_lo;
      req_src_port    <= r.sport;
      req_dst_port    <= r.dport;
      req_protocol    <= r.proto;
      req_action_code <= r.action;
      req_hop_addr_hi <= r.hop_hi;
      req_hop_addr_lo <= r.hop_lo;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // stop sending and wait until every expected result has come
   task automatic wait_drained();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_bypass_port(logic [15:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      bypass_port = value;
   endtask

   // result check against the oldest expectation
   always @(posedge clock) begin
      result_type e;
      if (!reset && rsp_vld) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual status %0d",
                     $time, rsp_status);
            error_count++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_status !== e.status || rsp_next_hop_hi !== e.hop_hi ||
                rsp_next_hop_lo !== e.hop_lo || rsp_entry_index !== e.index ||
                rsp_entry_total !== e.total || rsp_log_src_byte !== e.src_byte ||
                rsp_log_dst_byte !== e.dst_byte || rsp_log_src_port !== e.src_port ||
                rsp_log_dst_port !== e.dst_port || rsp_log_total !== e.log_total) begin
               $display("%0t: expected st %0d hop %h_%h idx %0d tot %0d log %h %h %h %h n %0d",
                        $time, e.status, e.hop_hi, e.hop_lo, e.index, e.total,
                        e.src_byte, e.dst_byte, e.src_port, e.dst_port, e.log_total);
               $display("%0t: actual   st %0d hop %h_%h idx %0d tot %0d log %h %h %h %h n %0d",
                        $time, rsp_status, rsp_next_hop_hi, rsp_next_hop_lo,
                        rsp_entry_index, rsp_entry_total, rsp_log_src_byte,
                        rsp_log_dst_byte, rsp_log_src_port, rsp_log_dst_port,
                        rsp_log_total);
               error_count++;
            end
         end
      end
   end

   // watchdog: cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_vld) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   row_type rows [NUM_ROWS];

   function automatic request_type make_req(wfte_pkg::op_type op, logic [7:0] fid,
                                            logic [63:0] a,
                                            logic [15:0] sp, logic [15:0] dp,
                                            logic [7:0] pr, logic [7:0] act);
      request_type r;
      r = '{op, fid, a, a, ~a, ~a, sp, dp, pr, act, ~a ^ 64'h5a, a ^ 64'ha5};
      return r;
   endfunction

   initial begin
      request_type r;
      result_type  exp_res;
      row_type     row;
      error_count     = 0;
      row_errors      = 0;
      flow_count      = 0;
      miss_count      = 0;
      bypass_port     = 16'd5683;
      reset           = 1'b1;
      start           = 1'b0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      req_opcode      = '0;
      req_flow_id     = '0;
      req_src_addr_hi = '0;
      req_src_addr_lo = '0;
      req_dst_addr_hi = '0;
      req_dst_addr_lo = '0;
      req_src_port    = '0;
      req_dst_port    = '0;
      req_protocol    = '0;
      req_action_code = '0;
      req_hop_addr_hi = '0;
      req_hop_addr_lo = '0;
      foreach (addr_pool[i]) addr_pool[i] = rand64();
      addr_pool[0] = '0;
      addr_pool[3] = '1;

      // directed rows: empty log, extremes, every action, wildcards, deletes
      rows[0]  = '{make_req(wfte_pkg::OP_DRAIN, 0, 0, 0, 0, 0, 0),
                   1, wfte_pkg::ST_LOG_EMPTY};
      rows[1]  = '{make_req(wfte_pkg::OP_DELETE, 8'hff, 0, 0, 0, 0, 0),
                   1, wfte_pkg::ST_NOT_FOUND};
      rows[2]  = '{make_req(wfte_pkg::OP_LOOKUP, 0, '1, 16'hffff, 16'hffff, 8'hff, 0),
                   1, wfte_pkg::ST_MISS_LOG};
      rows[3]  = '{make_req(wfte_pkg::OP_LOOKUP, 0, 0, 16'd5683, 1, 0, 0),
                   1, wfte_pkg::ST_BYPASS};
      rows[4]  = '{make_req(wfte_pkg::OP_INSERT, 8'h00, 0, 0, 0, 0, 8'd0),
                   1, wfte_pkg::ST_INSERTED};
      rows[5]  = '{make_req(wfte_pkg::OP_INSERT, 8'hff, '1, 16'hffff, 16'hffff, 8'hff, 8'd2),
                   1, wfte_pkg::ST_INSERTED};
      rows[6]  = '{make_req(wfte_pkg::OP_INSERT, 8'h10, 64'h1, 7, 0, 0, 8'hff),
                   1, wfte_pkg::ST_INSERTED};
      rows[7]  = '{make_req(wfte_pkg::OP_LOOKUP, 0, 0, 16'h1234, 16'h4321, 8'h11, 0),
                   0, wfte_pkg::ST_FORWARD};
      rows[8]  = '{make_req(wfte_pkg::OP_LOOKUP, 0, '1, 16'hffff, 16'hffff, 8'hff, 0),
                   0, wfte_pkg::ST_CONTROL};
      rows[9]  = '{make_req(wfte_pkg::OP_LOOKUP, 0, '1, 16'hfffe, 16'hffff, 8'hff, 0),
                   1, wfte_pkg::ST_MISS_LOG};
      rows[10] = '{make_req(wfte_pkg::OP_LOOKUP, 0, 64'h1, 7, 16'h9, 8'h6, 0),
                   1, wfte_pkg::ST_DROP};
      rows[11] = '{make_req(wfte_pkg::OP_INSERT, 8'hff, '1, 0, 0, 0, 8'd0),
                   1, wfte_pkg::ST_UPDATED};
      rows[12] = '{make_req(wfte_pkg::OP_INSERT, 8'h10, 64'h2, 0, 0, 0, 8'd1),
                   0, wfte_pkg::ST_UPDATED};
      rows[13] = '{make_req(wfte_pkg::OP_DELETE, 8'h00, 0, 0, 0, 0, 0),
                   1, wfte_pkg::ST_DELETED};
      rows[14] = '{make_req(wfte_pkg::OP_LOOKUP, 0, '1, 16'h1, 16'h2, 8'h3, 0),
                   0, wfte_pkg::ST_FORWARD};
      rows[15] = '{make_req(wfte_pkg::OP_DELETE, 8'h00, 0, 0, 0, 0, 0),
                   1, wfte_pkg::ST_NOT_FOUND};
      rows[16] = '{make_req(wfte_pkg::OP_DRAIN, 0, 0, 0, 0, 0, 0),
                   1, wfte_pkg::ST_RECORD};
      rows[17] = '{make_req(wfte_pkg::OP_DRAIN, 0, 0, 0, 0, 0, 0),
                   1, wfte_pkg::ST_RECORD};
      rows[18] = '{make_req(wfte_pkg::OP_DRAIN, 0, 0, 0, 0, 0, 0),
                   1, wfte_pkg::ST_LOG_EMPTY};
      rows[19] = '{make_req(wfte_pkg::OP_DELETE, 8'h10, 0, 0, 0, 0, 0),
                   1, wfte_pkg::ST_DELETED};
      rows[20] = '{make_req(wfte_pkg::OP_DELETE, 8'hff, 0, 0, 0, 0, 0),
                   1, wfte_pkg::ST_DELETED};
      rows[21] = '{make_req(wfte_pkg::OP_LOOKUP, 0, '1, 16'h0, 16'h0, 8'h0, 0),
                   1, wfte_pkg::ST_MISS_LOG};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_ROWS; i++) begin
         row = rows[i];
         exp_res = table_step(row.req);
         if (row.typed && exp_res.status != row.status) begin
            $display("%0t: row %0d expected status %0d, actual model status %0d",
                     $time, i, row.status, exp_res.status);
            row_errors++;
         end
         send_request(row.req, exp_res);
      end

      // random phases, each under its own reserved port setting
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: write_bypass_port(16'd0);
            1: write_bypass_port(16'hffff);
            2: write_bypass_port(16'($urandom_range(1, 3)));
            default: write_bypass_port(16'd5683);
         endcase
         for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
            r = random_request();
            // in phase 2, fill the table and the log first to reach the full cases
            if (phase == 2 && n < 60) begin
               r.op = (n < 35) ? wfte_pkg::OP_INSERT : wfte_pkg::OP_LOOKUP;
               if (n < 35) r.fid = 8'(100 + n);
               else r.src_hi = rand64();
            end
            send_request(r, table_step(r));
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (error_count == 0 && row_errors == 0 && pending_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
